@@ hdl/dlpa_pkg.sv @@
package dlpa_pkg;

  // register widths and codes
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned TimeW   = 32;

  localparam logic [CfgIdxW-1:0] CfgDebounceIdx = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHoldIdx     = 1'b1;

  localparam logic [CfgW-1:0] DebounceReset = 16'd50;
  localparam logic [CfgW-1:0] HoldReset     = 16'd2000;

  // one poll sample
  typedef struct packed {
    logic             raw_level;
    logic [TimeW-1:0] now_ms;
  } in_t;

  // one result item
  typedef struct packed {
    logic pressed;
    logic armed_pulse;
    logic shutdown_request;
  } out_t;

  // live configuration
  typedef struct packed {
    logic [CfgW-1:0] debounce_stable_ms;
    logic [CfgW-1:0] hold_threshold_ms;
  } cfg_t;

endpackage

@@ hdl/dlpa_cfg.sv @@
module dlpa_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dlpa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dlpa_pkg::CfgW-1:0]     cfg_data_i,
  output dlpa_pkg::cfg_t                cfg_o
);
  import dlpa_pkg::*;

  cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDebounceIdx: cfg_d.debounce_stable_ms = cfg_data_i;
        CfgHoldIdx:     cfg_d.hold_threshold_ms  = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_stable_ms <= DebounceReset;
      cfg_q.hold_threshold_ms  <= HoldReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/dlpa_core.sv @@
module dlpa_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  dlpa_pkg::in_t   item_i,
  input  dlpa_pkg::cfg_t  cfg_i,
  output dlpa_pkg::out_t  result_o
);
  import dlpa_pkg::*;

  logic             last_raw_q, last_raw_d;
  logic             stable_q, stable_d;
  logic [TimeW-1:0] change_time_q, change_time_d;
  logic             release_seen_q, release_seen_d;
  logic             held_q, held_d;
  logic             armed_q, armed_d;
  logic [TimeW-1:0] press_start_q, press_start_d;

  logic [TimeW-1:0] stable_elapsed;
  logic [TimeW-1:0] hold_elapsed;
  logic             is_pressed;

  // debounce on last change time, then press tracking
  always_comb begin
    last_raw_d     = item_i.raw_level;
    change_time_d  = (item_i.raw_level != last_raw_q) ? item_i.now_ms : change_time_q;
    stable_elapsed = item_i.now_ms - change_time_d;
    stable_d       = stable_q;
    if (stable_elapsed >= {{(TimeW-CfgW){1'b0}}, cfg_i.debounce_stable_ms}) begin
      stable_d = item_i.raw_level;
    end
    is_pressed     = !stable_d;
    hold_elapsed   = item_i.now_ms - press_start_q;

    release_seen_d = release_seen_q;
    held_d         = held_q;
    armed_d        = armed_q;
    press_start_d  = press_start_q;
    result_o.pressed          = is_pressed;
    result_o.armed_pulse      = 1'b0;
    result_o.shutdown_request = 1'b0;

    if (!release_seen_q) begin
      if (!is_pressed) begin
        release_seen_d = 1'b1;
      end
    end else if (is_pressed) begin
      if (!held_q) begin
        held_d        = 1'b1;
        armed_d       = 1'b0;
        press_start_d = item_i.now_ms;
      end else if (!armed_q &&
                   hold_elapsed >= {{(TimeW-CfgW){1'b0}}, cfg_i.hold_threshold_ms}) begin
        armed_d              = 1'b1;
        result_o.armed_pulse = 1'b1;
      end
    end else if (held_q) begin
      result_o.shutdown_request = armed_q;
      held_d                    = 1'b0;
      armed_d                   = 1'b0;
    end
  end

  // state advances once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q     <= 1'b1;
      stable_q       <= 1'b1;
      change_time_q  <= '0;
      release_seen_q <= 1'b0;
      held_q         <= 1'b0;
      armed_q        <= 1'b0;
      press_start_q  <= '0;
    end else if (fire_i) begin
      last_raw_q     <= last_raw_d;
      stable_q       <= stable_d;
      change_time_q  <= change_time_d;
      release_seen_q <= release_seen_d;
      held_q         <= held_d;
      armed_q        <= armed_d;
      press_start_q  <= press_start_d;
    end
  end

endmodule

@@ hdl/debounced_long_press_arm_top.sv @@
// channel   direction  handshake                  payload
// in        sink       in_valid_i / in_ready_o    in_data_i  (dlpa_pkg::in_t)
// out       source     out_valid_o / out_ready_i  out_data_o (dlpa_pkg::out_t)
// cfg       sink       cfg_we_i                   cfg_idx_i, cfg_data_i
//
// one item per cycle sustained while out_ready_i stays high; two register
// stages, input then output; a result waits in the output register until taken
// the register-to-register path is the input register, one 32-bit subtract
// and compare per timer, and the result register
// reset brings the debounced level to released and clears press tracking
// a stalled result holds the output register; the input register still
// takes an item while it is empty
module debounced_long_press_arm_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dlpa_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dlpa_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [dlpa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dlpa_pkg::CfgW-1:0]     cfg_data_i
);
  import dlpa_pkg::*;

  in_t  in_q;
  logic in_valid_q;
  out_t out_q;
  logic out_valid_q;
  out_t result;
  cfg_t cfg;
  logic advance;
  logic fire;

  // pipeline control
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  dlpa_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dlpa_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
